FILE: sv/ccs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants of the comment stripper: character codes,
// comment modes, the result word and the push group into the result queue.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        MODE_OUT   = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_BLOCK = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_text;
    } res_word_t;

    // up to two results per input word; p1 is set only together with p0
    typedef struct packed {
        logic      p0;
        res_word_t d0;
        logic      p1;
        res_word_t d1;
    } push_t;

endpackage

FILE: sv/ccs_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_in_if / ccs_out_if
// Valid/ready channels of the comment stripper: raw text words in,
// stripped result words out.
// ----------------------------------------------------------------------------
interface ccs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface ccs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;

    modport source (output valid, output out_byte, output byte_valid,
                    output end_of_text, input ready);
    modport sink (input valid, input out_byte, input byte_valid,
                  input end_of_text, output ready);
endinterface

FILE: sv/ccs_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_judge
// Input register plus the per-byte judge: holds one byte back, tracks the
// comment mode and emits up to two result words per input word.
// ----------------------------------------------------------------------------
module ccs_judge (
    input  logic            clk,
    input  logic            rst_n,
    ccs_in_if.sink          in_ch,
    input  logic            room,
    output ccs_pkg::push_t  push
);
    import ccs_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic [7:0] before_reg, before_next;
    mode_t      mode_reg, mode_next;

    logic       accept;
    logic       fire;
    mode_t      mode_a;
    mode_t      mode_b;
    logic       keep;

    assign fire        = in_valid_reg && room;
    assign in_ch.ready = !in_valid_reg || room;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        // open a comment on slash-slash or slash-star
        mode_a = mode_reg;
        if (mode_reg == MODE_OUT && held_byte_reg == CH_SLASH)
        begin
            if (in_byte_reg == CH_SLASH)
                mode_a = MODE_LINE;
            else if (in_byte_reg == CH_STAR)
                mode_a = MODE_BLOCK;
        end
        keep = (mode_a == MODE_OUT) || (held_byte_reg == CH_NEWLINE);

        // close on star-slash or on newline
        mode_b = mode_a;
        if (mode_a == MODE_BLOCK && before_reg == CH_STAR && held_byte_reg == CH_SLASH)
            mode_b = MODE_OUT;
        else if (mode_a == MODE_LINE && held_byte_reg == CH_NEWLINE)
            mode_b = MODE_OUT;
        if (!held_valid_reg)
            mode_b = mode_reg;
    end

    always_comb
    begin
        res_word_t held_res;
        res_word_t last_res;

        held_res.out_byte    = held_byte_reg;
        held_res.byte_valid  = 1'b1;
        held_res.end_of_text = 1'b0;

        last_res.out_byte    = (mode_b == MODE_OUT) ? in_byte_reg : 8'h00;
        last_res.byte_valid  = (mode_b == MODE_OUT);
        last_res.end_of_text = 1'b1;

        push = '0;
        if (fire)
        begin
            if (held_valid_reg && keep)
            begin
                push.p0 = 1'b1;
                push.d0 = held_res;
                if (in_last_reg)
                begin
                    push.p1 = 1'b1;
                    push.d1 = last_res;
                end
            end
            else if (in_last_reg)
            begin
                push.p0 = 1'b1;
                push.d0 = last_res;
            end
        end
    end

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        before_next     = before_reg;
        mode_next       = mode_reg;

        if (fire)
        begin
            in_valid_next = 1'b0;
            if (in_last_reg)
            begin
                // text ends: back to the reset state
                held_valid_next = 1'b0;
                before_next     = 8'h00;
                mode_next       = MODE_OUT;
            end
            else
            begin
                held_valid_next = 1'b1;
                held_byte_next  = in_byte_reg;
                mode_next       = mode_b;
                if (held_valid_reg)
                    before_next = held_byte_reg;
            end
        end
        if (accept)
            in_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            before_reg     <= 8'h00;
            mode_reg       <= MODE_OUT;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            held_valid_reg <= held_valid_next;
            before_reg     <= before_next;
            mode_reg       <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= in_ch.in_byte;
            in_last_reg <= in_ch.is_last;
        end
        held_byte_reg <= held_byte_next;
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_last_reg) |=> (!held_valid_reg && mode_reg == MODE_OUT
                                   && before_reg == 8'h00))
        else $error("state not cleared after last word");

    a_no_held_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!held_valid_reg && push.p0) |-> push.d0.end_of_text)
        else $error("byte result without a held byte");

    a_push_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        push.p0 |-> fire)
        else $error("result pushed without an advancing word");

endmodule

FILE: sv/ccs_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_out_queue
// Small result queue: takes up to two words a cycle from the judge and
// hands one word a cycle to a ready output channel from a register.
// ----------------------------------------------------------------------------
module ccs_out_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  ccs_pkg::push_t  push,
    output logic            room,
    ccs_out_if.source       out_ch
);
    import ccs_pkg::*;

    res_word_t           entries [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QPTR_W-1:0]   wr_ptr_inc;
    logic                pop;
    res_word_t           head;

    assign wr_ptr_inc = wr_ptr_reg + QPTR_W'(1);
    assign room       = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign pop        = out_ch.valid && out_ch.ready;
    assign head       = entries[rd_ptr_reg];

    assign out_ch.valid       = (count_reg != '0);
    assign out_ch.out_byte    = head.out_byte;
    assign out_ch.byte_valid  = head.byte_valid;
    assign out_ch.end_of_text = head.end_of_text;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.p0) + QPTR_W'(push.p1);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.p0) + QCNT_W'(push.p1) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.p0)
            entries[wr_ptr_reg] <= push.d0;
        if (push.p1)
            entries[wr_ptr_inc] <= push.d1;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.p0 |-> count_reg <= QCNT_W'(QDEPTH - 2))
        else $error("push without room for two words");

    a_pair_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        push.p1 |-> (push.p0 && push.d1.end_of_text && !push.d0.end_of_text))
        else $error("second result out of order");

endmodule

FILE: sv/c_comment_stripper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_comment_stripper_unit
// Removes C and C++ comments from a byte stream, one text byte per word.
// ----------------------------------------------------------------------------
// The unit takes one text byte per cycle on in_ch and returns the kept bytes
// on out_ch; each byte is judged once the next byte has arrived, so a byte
// leaves after its successor is taken. Newlines inside comments are kept.
// The word with is_last set closes the text: it yields a final word with
// end_of_text set, carrying that byte only if no comment is open, and the
// unit then starts afresh. An input word is held in the input
// register, then its results enter a four-word queue whose head drives
// out_ch directly. Input runs at one word per cycle; the output port moves
// one word per cycle while out_ch is ready, so a last word that also
// releases a held byte yields two output words. Input stalls only when
// the queue holds more than two words.
module c_comment_stripper_unit (
    input  logic       clk,
    input  logic       rst_n,
    ccs_in_if.sink     in_ch,
    ccs_out_if.source  out_ch
);
    import ccs_pkg::*;

    push_t push;
    logic  room;

    ccs_judge u_judge (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .room  (room),
        .push  (push)
    );

    ccs_out_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .out_ch (out_ch)
    );

endmodule
